@@ rtl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, types and codes for the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int DEPTH = 256;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 9;
  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REL_EQ = 2'd0,
    REL_GT = 2'd1,
    REL_LT = 2'd2
  } rel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // per-cell control, broadcast along the row
  typedef struct packed {
    logic             cmp;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  // registered compare result of one cell
  typedef struct packed {
    logic eq;
    logic gt;
  } cell_flag_t;

  // search outcome, valid for one cycle when done is high
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] pos;
    rel_t             rel;
  } srch_res_t;

endpackage

`default_nettype wire

@@ rtl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key, compares it with the broadcast key and takes
// its left neighbour's key or the new key during an insert shift.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  skt_pkg::cell_ctl_t        ctl,
  input  wire                       ld_key,
  input  wire                       ld_prev,
  input  wire [skt_pkg::KEY_W-1:0]  prev_entry,
  output logic [skt_pkg::KEY_W-1:0] entry,
  output skt_pkg::cell_flag_t       flag
);
  import skt_pkg::*;

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ld_key) begin
      entry <= ctl.key;
    end else if (ld_prev) begin
      entry <= prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= '0;
    end else if (ctl.cmp) begin
      flag.eq <= (entry == ctl.key);
      flag.gt <= (entry > ctl.key);
    end
  end

endmodule

`default_nettype wire

@@ rtl/skt_search.sv @@
// ----------------------------------------------------------------------------
// skt_search
// Binary-search sequencer over the registered cell flags: one probe a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_search (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire [skt_pkg::CNT_W-1:0]            cnt,
  input  skt_pkg::cell_flag_t [skt_pkg::DEPTH-1:0] flags,
  output skt_pkg::srch_res_t                  res
);
  import skt_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] first;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] first_next;
  logic [IDX_W-1:0] last_next;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] span;
  logic [CNT_W-1:0] cnt_m1;
  cell_flag_t       probe;

  assign span   = last - first;
  assign mid    = first + (span >> 1);
  assign probe  = flags[mid];
  assign cnt_m1 = cnt - CNT_W'(1);

  always_comb begin
    res        = '0;
    res.rel    = REL_EQ;
    first_next = first;
    last_next  = last;
    if (busy) begin
      if (probe.eq) begin
        res.done  = 1'b1;
        res.found = 1'b1;
        res.pos   = mid;
      end else if (span == '0) begin
        res.done = 1'b1;
        res.pos  = first;
        res.rel  = probe.gt ? REL_GT : REL_LT;
      end else if (probe.gt) begin
        if (span == IDX_W'(1)) begin
          res.done = 1'b1;
          res.pos  = first;
          res.rel  = REL_GT;
        end else begin
          last_next = mid - IDX_W'(1);
        end
      end else begin
        first_next = mid + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (res.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      first <= '0;
      last  <= cnt_m1[IDX_W-1:0];
    end else begin
      first <= first_next;
      last  <= last_next;
    end
  end

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    busy |-> first <= last) else $error("search window inverted");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    res.done |-> busy) else $error("search done while idle");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("search restarted while busy");

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_search_insert_top.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_top
// Sorted key table with binary-search lookup, sorted insert and clear.
// ----------------------------------------------------------------------------
// A clear goes from acceptance to the result state with no search. A lookup
// runs binary-search probes (1 to 9 probes for 256 entries), and an
// insert then shifts the cell row unless the table is full; an empty table
// needs no probe. The probe sequencer resolves one probe a cycle from the
// compare flags that the cells register when the word is accepted. One word
// is in work at a time; a finished result waits in the output register while
// the next word is taken.
`default_nettype none

module sorted_key_table_search_insert_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [skt_pkg::FUNC_W-1:0]  func,
  input  wire [skt_pkg::KEY_W-1:0]   key,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       status,
  output logic                       found,
  output logic [skt_pkg::POS_W-1:0]  position,
  output logic [1:0]                 relation,
  output logic [skt_pkg::CNT_W-1:0]  count
);
  import skt_pkg::*;

  state_t            state;
  state_t            state_next;
  logic              in_acc;
  logic              out_load;
  op_t               op_in;
  op_t               op;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  entry_cnt;
  logic              tbl_full;
  logic              srch_start;
  srch_res_t         srch;
  logic              res_status;
  logic              res_found;
  logic [IDX_W-1:0]  res_pos;
  rel_t              res_rel;
  logic [IDX_W-1:0]  at;
  logic              shift_en;
  cell_ctl_t         ctl;
  cell_flag_t [DEPTH-1:0]       flags;
  logic [DEPTH-1:0][KEY_W-1:0]  entries;

  assign op_in      = op_t'(func);
  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign tbl_full   = (entry_cnt == CNT_W'(DEPTH));
  assign srch_start = in_acc && (op_in != OP_CLEAR) && (entry_cnt != '0);
  assign at         = (res_rel == REL_LT) ? res_pos + IDX_W'(1) : res_pos;
  assign shift_en   = (state == ST_SHIFT);
  assign out_load   = (state == ST_DONE) && (!out_valid || out_ready);

  assign ctl.cmp = in_acc;
  assign ctl.key = (state == ST_IDLE) ? key : key_q;

  // cell row: on a shift, each cell above the insert point takes its left neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = entries[i-1];
    end
    skt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .ld_key     (shift_en && (at == IDX_W'(i))),
      .ld_prev    (shift_en && (at < IDX_W'(i))),
      .prev_entry (prev),
      .entry      (entries[i]),
      .flag       (flags[i])
    );
  end

  skt_search u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .cnt   (entry_cnt),
    .flags (flags),
    .res   (srch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_in == OP_CLEAR) begin
            state_next = ST_DONE;
          end else if (entry_cnt == '0) begin
            state_next = (op_in == OP_INSERT) ? ST_SHIFT : ST_DONE;
          end else begin
            state_next = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (srch.done) begin
          state_next = ((op == OP_INSERT) && !tbl_full) ? ST_SHIFT : ST_DONE;
        end
      end
      ST_SHIFT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_cnt <= '0;
    end else if (in_acc && (op_in == OP_CLEAR)) begin
      entry_cnt <= '0;
    end else if (shift_en) begin
      entry_cnt <= entry_cnt + CNT_W'(1);
    end
  end

  // working word and search result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op         <= op_in;
      key_q      <= key;
      res_status <= 1'b0;
      res_found  <= 1'b0;
      res_pos    <= '0;
      res_rel    <= REL_EQ;
    end else if ((state == ST_SRCH) && srch.done) begin
      res_status <= (op == OP_INSERT) && tbl_full;
      res_found  <= srch.found;
      res_pos    <= srch.pos;
      res_rel    <= srch.rel;
    end else if (shift_en) begin
      res_pos <= at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= res_status;
      found    <= res_found;
      position <= POS_W'(res_pos);
      relation <= res_rel;
      count    <= entry_cnt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> count == CNT_W'(DEPTH))
    else $error("full status with room left");

  a_found_rel: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> relation == REL_EQ)
    else $error("found word with unequal relation");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count != '0) |-> position < POS_W'(count))
    else $error("position beyond table");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op_in == OP_CLEAR) |=> entry_cnt == '0)
    else $error("clear left entries");

endmodule

`default_nettype wire

@@ dv/sorted_key_table_search_insert_top_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert_top_tb
// Drives lookups, sorted inserts, clears and the spare code into the sorted key
// table. A scoreboard keeps its own copy of the table, and from it works out
// the expected status, found flag, position, relation and count of every
// word. Each result is checked in order against those expectations. The run
// fills the table to capacity several times, under changing back-pressure.
// ----------------------------------------------------------------------------

module sorted_key_table_search_insert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  typedef struct {
    logic             status;
    logic             found;
    logic [POS_W-1:0] position;
    rel_t             relation;
    logic [CNT_W-1:0] count;
  } table_result_t;

  class table_scoreboard;
    logic [KEY_W-1:0] entries [DEPTH];
    int unsigned      held;
    table_result_t    awaited [$];
    int unsigned      errors;
    int unsigned      n_words, n_checked, n_found, n_refused, n_clears;

    function int unsigned pending();
      return awaited.size();
    endfunction

    // binary search over the occupied entries
    function void probe(input logic [KEY_W-1:0] k, output logic hit,
                        output int unsigned idx, output rel_t rel);
      int unsigned lo, hi, mid;
      hit = 1'b0;
      idx = 0;
      rel = REL_EQ;
      if (held == 0) return;
      lo = 0;
      hi = held - 1;
      forever begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == k) begin
          hit = 1'b1;
          idx = mid;
          return;
        end
        if (lo == hi) begin
          idx = lo;
          rel = (entries[mid] > k) ? REL_GT : REL_LT;
          return;
        end
        if (entries[mid] > k) begin
          // two left and the middle is greater: stop at the lower one
          if (hi - lo == 1) begin
            idx = lo;
            rel = REL_GT;
            return;
          end
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    endfunction

    function void note_word(input op_t op, input logic [KEY_W-1:0] k);
      table_result_t r;
      logic          hit;
      int unsigned   idx, dst, i;
      rel_t          rel;
      n_words++;
      r.status   = 1'b0;
      r.found    = 1'b0;
      r.position = '0;
      r.relation = REL_EQ;
      if (op == OP_CLEAR) begin
        held = 0;
        n_clears++;
      end else begin
        probe(k, hit, idx, rel);
        r.found    = hit;
        r.position = POS_W'(idx);
        r.relation = rel;
        if (hit) n_found++;
        if (op == OP_INSERT) begin
          if (held >= DEPTH) begin
            r.status = 1'b1;
            n_refused++;
          end else begin
            dst = (rel == REL_LT) ? idx + 1 : idx;
            if (dst > held) dst = held;
            for (i = held; i > dst; i--) entries[i] = entries[i-1];
            entries[dst] = k;
            held++;
            r.position = POS_W'(dst);
          end
        end
      end
      r.count = CNT_W'(held);
      awaited.push_back(r);
    endfunction

    function void check_result(input logic st, input logic fd,
                               input logic [POS_W-1:0] pos, input logic [1:0] rel,
                               input logic [CNT_W-1:0] cnt);
      table_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result word with none awaited", $time);
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      if (st !== e.status || fd !== e.found || pos !== e.position ||
          rel !== e.relation || cnt !== e.count) begin
        errors++;
        if (errors <= 10)
          $display("%0t: got st %0d fd %0d pos %0d rel %0d cnt %0d, want %0d %0d %0d %0d %0d",
                   $time, st, fd, pos, rel, cnt,
                   e.status, e.found, e.position, e.relation, e.count);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [FUNC_W-1:0] func = '0;
  logic [KEY_W-1:0] key = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             status;
  logic             found;
  logic [POS_W-1:0] position;
  logic [1:0]       relation;
  logic [CNT_W-1:0] count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  table_scoreboard sb = new();

  sorted_key_table_search_insert_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .position  (position),
    .relation  (relation),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("sorted_key_table_search_insert_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(op_t'(func), key);
      if (out_valid && out_ready) sb.check_result(status, found, position, relation, count);
    end
  end

  // valid is only lowered for an idle gap, never between back-to-back words
  task automatic send_word(input op_t op, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // extremes, a crowded low range for duplicates, and keys next to held ones
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    case ($urandom_range(9))
      0:       k = $urandom_range(1) ? ~KEY_W'($urandom_range(3)) : KEY_W'($urandom_range(3));
      1, 2:    k = KEY_W'($urandom_range(47));
      3, 4, 5: if (sb.held != 0)
                 k = sb.entries[$urandom_range(sb.held - 1)] + KEY_W'($urandom_range(2)) - 1'b1;
      default: ;
    endcase
    return k;
  endfunction

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_mixed);
    int unsigned inserts, roll;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_word(OP_CLEAR, $urandom);
    inserts = 0;
    // fill to capacity, then a few inserts against the full table
    while (inserts < DEPTH + 4) begin
      roll = $urandom_range(9);
      if (roll < 8) begin
        send_word(OP_INSERT, pick_key());
        inserts++;
      end else begin
        send_word(roll == 9 ? OP_SPARE : OP_LOOKUP, pick_key());
      end
    end
    repeat (12) send_word(OP_LOOKUP, pick_key());
    repeat (n_mixed) begin
      roll = $urandom_range(99);
      if (roll < 45)      send_word(OP_LOOKUP, pick_key());
      else if (roll < 88) send_word(OP_INSERT, pick_key());
      else if (roll < 93) send_word(OP_SPARE, pick_key());
      else                send_word(OP_CLEAR, pick_key());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 88;
    send_word(OP_LOOKUP, '0);          // empty table
    send_word(OP_INSERT, 100);         // insert into empty
    send_word(OP_LOOKUP, 100);
    send_word(OP_LOOKUP, 50);
    send_word(OP_LOOKUP, 200);
    send_word(OP_INSERT, 100);         // duplicate lands before its equal
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, 50);
    send_word(OP_INSERT, 150);
    send_word(OP_LOOKUP, '0);
    send_word(OP_LOOKUP, '1);
    send_word(OP_LOOKUP, 149);
    send_word(OP_LOOKUP, 151);
    send_word(OP_SPARE, '1);           // spare code acts as a lookup
    send_word(OP_SPARE, 100);
    send_word(OP_CLEAR, 100);
    send_word(OP_LOOKUP, 100);         // cleared table reads as empty
    send_word(OP_INSERT, 7);
    send_word(OP_CLEAR, '0);

    run_phase(14, 88, 60);
    run_phase(88, 14, 60);
    run_phase(0, 0, 60);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d words and %0d results: %0d searches hit, %0d clears",
             sb.n_words, sb.n_checked, sb.n_found, sb.n_clears);
    $display("table filled three times, %0d inserts refused when full, %0d mismatches",
             sb.n_refused, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_key_table_search_insert_top_tb: clean");
    end else begin
      $display("sorted_key_table_search_insert_top_tb: errors");
    end
    $finish;
  end

endmodule
